>>> rtl/core/wua_pkg.sv
`timescale 1ns / 1ps
package wua_pkg;

   localparam int WORD_W  = 64;
   localparam int DATA_W  = 256;
   localparam int SHAMT_W = 9;
   localparam int OP_W    = 4;
   localparam int CMP_W   = 2;
   localparam int SUM_W   = DATA_W + 2;
   localparam int BIT_W   = $clog2(DATA_W);

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_AND = 4'd2,
      OP_OR  = 4'd3,
      OP_XOR = 4'd4,
      OP_NOT = 4'd5,
      OP_SHL = 4'd6,
      OP_SHR = 4'd7,
      OP_MUL = 4'd8,
      OP_DIV = 4'd9,
      OP_REM = 4'd10,
      OP_POW = 4'd11
   } op_type;

   localparam logic [CMP_W-1:0] CMP_EQ   = 2'd0;
   localparam logic [CMP_W-1:0] CMP_GT   = 2'd1;
   localparam logic [CMP_W-1:0] CMP_LT   = 2'd2;
   localparam logic [CMP_W-1:0] CMP_NONE = 2'd3;

endpackage

>>> rtl/core/wua_if.sv
`timescale 1ns / 1ps
interface wua_req_if;
   import wua_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [WORD_W-1:0]    a_word0;
   logic [WORD_W-1:0]    a_word1;
   logic [WORD_W-1:0]    a_word2;
   logic [WORD_W-1:0]    a_word3;
   logic [WORD_W-1:0]    b_word0;
   logic [WORD_W-1:0]    b_word1;
   logic [WORD_W-1:0]    b_word2;
   logic [WORD_W-1:0]    b_word3;
   logic [SHAMT_W-1:0]   shift_amount;

   modport source (output valid, op, a_word0, a_word1, a_word2, a_word3,
                   b_word0, b_word1, b_word2, b_word3, shift_amount,
                   input ready);
   modport sink   (input valid, op, a_word0, a_word1, a_word2, a_word3,
                   b_word0, b_word1, b_word2, b_word3, shift_amount,
                   output ready);
endinterface

interface wua_rsp_if;
   import wua_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [WORD_W-1:0]    r_word0;
   logic [WORD_W-1:0]    r_word1;
   logic [WORD_W-1:0]    r_word2;
   logic [WORD_W-1:0]    r_word3;
   logic                 carry_flag;
   logic [CMP_W-1:0]     compare_code;
   logic                 zero_divisor;

   modport source (output valid, r_word0, r_word1, r_word2, r_word3,
                   carry_flag, compare_code, zero_divisor, input ready);
   modport sink   (input valid, r_word0, r_word1, r_word2, r_word3,
                   carry_flag, compare_code, zero_divisor, output ready);
endinterface

>>> rtl/core/wua_shifter.sv
`timescale 1ns / 1ps
module wua_shifter
   import wua_pkg::*;
(
   input  logic [DATA_W-1:0]  data,
   input  logic [SHAMT_W-1:0] amount,
   input  logic               left,
   output logic [DATA_W-1:0]  result
);

   logic [BIT_W-1:0] shift_dist;

   assign shift_dist = amount[BIT_W-1:0];

   always_comb begin
      if (amount[SHAMT_W-1]) begin
         result = '0;
      end else if (left) begin
         result = data << shift_dist;
      end else begin
         result = data >> shift_dist;
      end
   end

endmodule

>>> rtl/core/wide_unsigned_alu_256_core.sv
`timescale 1ns / 1ps
// 256-bit unsigned ALU: add, sub, and, or, xor, not, shl, shr, mul, div, rem
// and pow, all modulo 2^256, with add carry, A-versus-B compare and a
// divide-by-zero flag. One word in flight at a time; req_bus.ready is low
// while an operation runs or an unread result blocks the output register.
// Logic ops, add, sub, shifts and division by zero return their result in the
// cycle after acceptance. Mul, div and rem make one pass per operand bit
// through a single shared 258-bit adder, and no new word is taken while the
// operation runs. Pow runs one multiply per exponent bit plus one more per
// set bit of B.
module wide_unsigned_alu_256_core
   import wua_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   wua_req_if.sink   req_bus,
   wua_rsp_if.source rsp_bus
);

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} state_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in, req_op;
   logic [DATA_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [DATA_W-1:0] acc_ff, acc_in, mx_ff, mx_in, my_ff, my_in;
   logic [BIT_W-1:0]  bit_ff, bit_in, ebit_ff, ebit_in;
   logic              phase_ff, phase_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] r_ff, r_in;
   logic              carry_ff, carry_in, dz_ff, dz_in;
   logic [CMP_W-1:0]  rcmp_ff, rcmp_in;

   logic [DATA_W-1:0] a_req, b_req, shl_out, shr_out, mul_out, quo_next, rem_next;
   logic [SUM_W-1:0]  add_x, add_y, sum;
   logic              add_cin, accept, take;
   logic [CMP_W-1:0]  cmp_req;

   assign a_req  = {req_bus.a_word0, req_bus.a_word1, req_bus.a_word2, req_bus.a_word3};
   assign b_req  = {req_bus.b_word0, req_bus.b_word1, req_bus.b_word2, req_bus.b_word3};
   assign req_op = op_type'(req_bus.op);

   assign req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   assign cmp_req = (a_req > b_req) ? CMP_GT : ((a_req < b_req) ? CMP_LT : CMP_EQ);

   wua_shifter u_shl (.data(a_req), .amount(req_bus.shift_amount), .left(1'b1),
                      .result(shl_out));
   wua_shifter u_shr (.data(a_req), .amount(req_bus.shift_amount), .left(1'b0),
                      .result(shr_out));

   // shared adder
   always_comb begin
      add_x   = {2'b00, a_req};
      add_y   = {2'b00, b_req};
      add_cin = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_op == OP_SUB) begin
               add_y   = ~{2'b00, b_req};
               add_cin = 1'b1;
            end
         end
         S_MUL: begin
            add_x = {2'b00, acc_ff[DATA_W-2:0], 1'b0};
            add_y = my_ff[DATA_W-1] ? {2'b00, mx_ff} : '0;
         end
         S_DIV: begin
            add_x   = {1'b0, acc_ff, my_ff[DATA_W-1]};
            add_y   = ~{2'b00, b_ff};
            add_cin = 1'b1;
         end
         default: ;
      endcase
   end

   assign sum      = add_x + add_y + {{(SUM_W-1){1'b0}}, add_cin};
   assign mul_out  = sum[DATA_W-1:0];
   assign take     = !sum[SUM_W-1];
   assign quo_next = {mx_ff[DATA_W-2:0], take};
   assign rem_next = take ? sum[DATA_W-1:0] : {acc_ff[DATA_W-2:0], my_ff[DATA_W-1]};

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      bit_in       = bit_ff;
      ebit_in      = ebit_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      r_in         = r_ff;
      carry_in     = carry_ff;
      dz_in        = dz_ff;
      rcmp_in      = rcmp_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               a_in     = a_req;
               b_in     = b_req;
               rcmp_in  = cmp_req;
               carry_in = 1'b0;
               dz_in    = 1'b0;
               r_in     = '0;
               acc_in   = '0;
               bit_in   = '1;
               ebit_in  = '1;
               phase_in = 1'b0;
               rsp_valid_in = 1'b1;
               case (req_op)
                  OP_ADD: begin
                     r_in     = sum[DATA_W-1:0];
                     carry_in = sum[DATA_W];
                  end
                  OP_SUB: r_in = sum[DATA_W-1:0];
                  OP_AND: r_in = a_req & b_req;
                  OP_OR:  r_in = a_req | b_req;
                  OP_XOR: r_in = a_req ^ b_req;
                  OP_NOT: r_in = ~a_req;
                  OP_SHL: r_in = shl_out;
                  OP_SHR: r_in = shr_out;
                  OP_MUL: begin
                     mx_in        = a_req;
                     my_in        = b_req;
                     state_in     = S_MUL;
                     rsp_valid_in = 1'b0;
                  end
                  OP_DIV, OP_REM: begin
                     if (b_req == '0) begin
                        dz_in = 1'b1;
                     end else begin
                        mx_in        = '0;
                        my_in        = a_req;
                        state_in     = S_DIV;
                        rsp_valid_in = 1'b0;
                     end
                  end
                  OP_POW: begin
                     mx_in        = {{(DATA_W-1){1'b0}}, 1'b1};
                     my_in        = {{(DATA_W-1){1'b0}}, 1'b1};
                     state_in     = S_MUL;
                     rsp_valid_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            acc_in = mul_out;
            my_in  = {my_ff[DATA_W-2:0], 1'b0};
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               acc_in = '0;
               bit_in = '1;
               if (op_ff != OP_POW) begin
                  r_in         = mul_out;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else if (!phase_ff && b_ff[ebit_ff]) begin
                  phase_in = 1'b1;
                  mx_in    = a_ff;
                  my_in    = mul_out;
               end else if (ebit_ff == '0) begin
                  r_in         = mul_out;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  ebit_in  = ebit_ff - 1'b1;
                  phase_in = 1'b0;
                  mx_in    = mul_out;
                  my_in    = mul_out;
               end
            end
         end
         S_DIV: begin
            acc_in = rem_next;
            mx_in  = quo_next;
            my_in  = {my_ff[DATA_W-2:0], 1'b0};
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               r_in         = (op_ff == OP_DIV) ? quo_next : rem_next;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      bit_ff   <= bit_in;
      ebit_ff  <= ebit_in;
      phase_ff <= phase_in;
      r_ff     <= r_in;
      carry_ff <= carry_in;
      dz_ff    <= dz_in;
      rcmp_ff  <= rcmp_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.r_word0      = r_ff[4*WORD_W-1:3*WORD_W];
   assign rsp_bus.r_word1      = r_ff[3*WORD_W-1:2*WORD_W];
   assign rsp_bus.r_word2      = r_ff[2*WORD_W-1:WORD_W];
   assign rsp_bus.r_word3      = r_ff[WORD_W-1:0];
   assign rsp_bus.carry_flag   = carry_ff;
   assign rsp_bus.compare_code = rcmp_ff;
   assign rsp_bus.zero_divisor = dz_ff;

endmodule

>>> rtl/core/wua_checker.sv
`timescale 1ns / 1ps
module wua_checker
   import wua_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [DATA_W-1:0]  rsp_data,
   input logic               rsp_carry,
   input logic [CMP_W-1:0]   rsp_cmp,
   input logic               rsp_dz
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data) && $stable(rsp_cmp))
      else $error("rsp word changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready && rsp_valid && !rsp_ready))
      else $error("req word taken while result blocked");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dz |-> (rsp_data == '0) && !rsp_carry)
      else $error("zero divisor with nonzero result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cmp != CMP_NONE)
      else $error("bad compare code");

endmodule

bind wide_unsigned_alu_256_core wua_checker u_wua_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  ({rsp_bus.r_word0, rsp_bus.r_word1, rsp_bus.r_word2, rsp_bus.r_word3}),
   .rsp_carry (rsp_bus.carry_flag),
   .rsp_cmp   (rsp_bus.compare_code),
   .rsp_dz    (rsp_bus.zero_divisor)
);
